>>> rtl/core/lmsd_pkg.sv
package lmsd_pkg;

  localparam int PANEL_COLUMNS = 64;
  localparam int ROW_PAIRS     = 16;

  localparam int PANEL_ROWS  = 4 * ROW_PAIRS;
  localparam int BUF_SIZE    = PANEL_COLUMNS * PANEL_ROWS;
  localparam int MEM_DEPTH   = 2 * BUF_SIZE;
  localparam int SHIFT_CLKS  = 2 * PANEL_COLUMNS;

  localparam int COL_W   = $clog2(PANEL_COLUMNS);
  localparam int ROW_W   = $clog2(PANEL_ROWS);
  localparam int PAIR_W  = $clog2(ROW_PAIRS);
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int CLK_W   = $clog2(SHIFT_CLKS);
  localparam int COLOR_W = 3;
  localparam int RGB_W   = 2 * COLOR_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SWAP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] pixel_x;
    logic [5:0] pixel_y;
    logic [2:0] pixel_color;
  } in_word_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [5:0] first_shift_rgb;
    logic [5:0] second_shift_rgb;
    logic       latch_now;
    logic       swapped;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SWAP,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] color;
  } qent_t;

  typedef struct packed {
    logic clear_done;
  } lmsd_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic buf_sel,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(buf_sel) * ADDR_W'(BUF_SIZE)
         + ADDR_W'(row) * ADDR_W'(PANEL_COLUMNS)
         + ADDR_W'(col);
  endfunction

endpackage

>>> rtl/core/lmsd_front.sv
module lmsd_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lmsd_pkg::in_word_t    in_word,
  input  lmsd_pkg::lmsd_status_t status,
  input  logic                  q_full,
  output logic                  q_push,
  output lmsd_pkg::qent_t       q_word
);
  import lmsd_pkg::*;

  logic keep;
  logic in_range;

  assign in_ready = status.clear_done & ~q_full;
  assign in_range = (int'(in_word.pixel_x) < PANEL_COLUMNS)
                 && (int'(in_word.pixel_y) < PANEL_ROWS);

  always_comb begin
    q_word.row   = ROW_W'(in_word.pixel_y);
    q_word.col   = COL_W'(in_word.pixel_x);
    q_word.color = in_word.pixel_color;
    q_word.op    = OP_WRITE;
    keep         = 1'b0;
    unique case (in_word.cmd)
      CMD_WRITE: begin
        q_word.op = OP_WRITE;
        keep      = in_range;
      end
      CMD_SWAP: begin
        q_word.op = OP_SWAP;
        keep      = 1'b1;
      end
      CMD_TICK: begin
        q_word.op = OP_TICK;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid & in_ready & keep;

endmodule

>>> rtl/core/lmsd_cmd_queue.sv
module lmsd_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lmsd_pkg::qent_t push_word,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output lmsd_pkg::qent_t pop_word
);
  import lmsd_pkg::*;

  qent_t             ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_word  = ent_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

>>> rtl/core/lmsd_back.sv
module lmsd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  lmsd_pkg::qent_t        q_word,
  output logic                   q_pop,
  output lmsd_pkg::lmsd_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lmsd_pkg::out_word_t    out_word
);
  import lmsd_pkg::*;

  logic [COLOR_W-1:0] mem [MEM_DEPTH];

  back_state_t        state_r, state_nxt;
  logic               disp_sel_r, disp_sel_nxt;
  logic               swap_pend_r, swap_pend_nxt;
  logic [PAIR_W-1:0]  row_pair_r, row_pair_nxt;
  logic               tick_sw_r, tick_sw_nxt;
  logic [CLK_W-1:0]   clk_cnt_r, clk_cnt_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;

  logic               rd_valid_r, rd_odd_r, rd_last_r;
  logic [COLOR_W-1:0] rd_up_r, rd_lo_r;
  logic [RGB_W-1:0]   first_hold_r;

  out_word_t          ob_r [2];
  logic               ob_wr_r, ob_rd_r;
  logic [1:0]         ob_cnt_r;
  logic               ob_push, ob_pop;

  logic               clr_last, scan_last, credit, issue, is_tick;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [COLOR_W-1:0] mem_wd;
  logic [ADDR_W-1:0]  ra_up, ra_lo;
  logic [PAIR_W-1:0]  row_next;
  logic [ROW_W-1:0]   up_row, lo_row;
  logic [COL_W-1:0]   col;

  assign clr_last  = (clr_addr_r == ADDR_W'(MEM_DEPTH - 1));
  assign scan_last = (clk_cnt_r == CLK_W'(SHIFT_CLKS - 1));
  assign credit    = ~clk_cnt_r[0] | ((ob_cnt_r + {1'b0, rd_valid_r & rd_odd_r}) < 2'd2);
  assign is_tick   = (q_word.op == OP_TICK);
  assign row_next  = (row_pair_r == PAIR_W'(ROW_PAIRS - 1)) ? '0 : row_pair_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid && is_tick) state_nxt = ST_SCAN;
      ST_SCAN:  if (issue && scan_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop             = 1'b0;
    issue             = 1'b0;
    status.clear_done = 1'b1;
    mem_we            = 1'b0;
    mem_wa            = pix_addr(~disp_sel_r, q_word.row, q_word.col);
    mem_wd            = q_word.color;
    unique case (state_r)
      ST_CLEAR: begin
        status.clear_done = 1'b0;
        mem_we            = 1'b1;
        mem_wa            = clr_addr_r;
        mem_wd            = '0;
      end
      ST_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid & (q_word.op == OP_WRITE);
      end
      ST_SCAN: begin
        issue = credit;
      end
      default: begin
        status.clear_done = 1'b0;
      end
    endcase
  end

  // shift clock to pixel addresses
  always_comb begin
    if (int'(clk_cnt_r) < PANEL_COLUMNS) begin
      col    = COL_W'(PANEL_COLUMNS - 1) - COL_W'(clk_cnt_r);
      up_row = ROW_W'(2 * ROW_PAIRS - 1) - ROW_W'(row_pair_r);
      lo_row = ROW_W'(ROW_PAIRS - 1) - ROW_W'(row_pair_r);
    end else begin
      col    = COL_W'(clk_cnt_r - CLK_W'(PANEL_COLUMNS));
      up_row = ROW_W'(2 * ROW_PAIRS) + ROW_W'(row_pair_r);
      lo_row = ROW_W'(3 * ROW_PAIRS) + ROW_W'(row_pair_r);
    end
    ra_up = pix_addr(disp_sel_r, up_row, col);
    ra_lo = pix_addr(disp_sel_r, lo_row, col);
  end

  always_comb begin
    disp_sel_nxt  = disp_sel_r;
    swap_pend_nxt = swap_pend_r;
    row_pair_nxt  = row_pair_r;
    tick_sw_nxt   = tick_sw_r;
    clk_cnt_nxt   = clk_cnt_r;
    if (q_pop) begin
      unique case (q_word.op)
        OP_SWAP: swap_pend_nxt = 1'b1;
        OP_TICK: begin
          row_pair_nxt = row_next;
          clk_cnt_nxt  = '0;
          tick_sw_nxt  = (row_next == '0) & swap_pend_r;
          if ((row_next == '0) && swap_pend_r) begin
            disp_sel_nxt  = ~disp_sel_r;
            swap_pend_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (issue) begin
      clk_cnt_nxt = clk_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      disp_sel_r  <= 1'b1;
      swap_pend_r <= 1'b0;
      row_pair_r  <= '0;
      tick_sw_r   <= 1'b0;
      clk_cnt_r   <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_r + 1'b1;
      disp_sel_r  <= disp_sel_nxt;
      swap_pend_r <= swap_pend_nxt;
      row_pair_r  <= row_pair_nxt;
      tick_sw_r   <= tick_sw_nxt;
      clk_cnt_r   <= clk_cnt_nxt;
      rd_valid_r  <= issue;
    end
  end

  // frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_up_r <= mem[ra_up];
    rd_lo_r <= mem[ra_lo];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_odd_r  <= clk_cnt_r[0];
      rd_last_r <= scan_last;
    end
    if (rd_valid_r && !rd_odd_r) begin
      first_hold_r <= {rd_up_r, rd_lo_r};
    end
  end

  // two-entry result buffer
  assign out_valid = (ob_cnt_r != 2'd0);
  assign out_word  = ob_r[ob_rd_r];
  assign ob_pop    = out_valid & out_ready;
  assign ob_push   = rd_valid_r & rd_odd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) ob_wr_r <= ~ob_wr_r;
      if (ob_pop)  ob_rd_r <= ~ob_rd_r;
      if (ob_push && !ob_pop) begin
        ob_cnt_r <= ob_cnt_r + 2'd1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_r <= ob_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_r[ob_wr_r].row_address      <= 4'(row_pair_r);
      ob_r[ob_wr_r].first_shift_rgb  <= first_hold_r;
      ob_r[ob_wr_r].second_shift_rgb <= {rd_up_r, rd_lo_r};
      ob_r[ob_wr_r].latch_now        <= rd_last_r;
      ob_r[ob_wr_r].swapped          <= tick_sw_r;
    end
  end

endmodule

>>> rtl/core/led_matrix_scan_driver_top.sv
// Scan driver for a 64x64 RGB panel of two chained 64x32 modules, double buffered.
// Input channel (in_valid/in_ready/in_word): one word per command. Pixel write and
// swap request produce no result; unused commands and writes off the panel are
// dropped at the input.
// A scan tick advances the row pair, exchanges buffers on wrap if a swap is
// pending, then produces 64 result words, one per pair of shift clocks; the
// last carries latch_now.
// Result channel (out_valid/out_ready/out_word): two-entry output buffer.
// A tick holds the back end while it takes the command and then reads the frame
// store through its two read ports (four pixels per result, two per cycle unless
// the receiver stalls).
// A four-deep command queue separates input acceptance from execution, so
// commands are taken while a tick is being shifted out.
// Receiver stall: reads pause once two results are waiting; nothing is lost.
// Reset: synchronous, active low. After reset the frame store is cleared one
// entry per cycle, all 8192 entries, with in_ready held low; the second buffer is
// displayed and the row pair is zero.
module led_matrix_scan_driver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmsd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output lmsd_pkg::out_word_t out_word
);
  import lmsd_pkg::*;

  lmsd_status_t status;
  logic         q_full, q_push, q_valid, q_pop;
  qent_t        q_in, q_out;

  lmsd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .status   (status),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_in)
  );

  lmsd_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_word  (q_out)
  );

  lmsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_out),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

>>> verif/tb_led_matrix_scan_driver_top.sv
module tb_led_matrix_scan_driver_top;
  import lmsd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 330;
  localparam int IDLE_PCT     = 29;

  class panel_scoreboard;
    logic [COLOR_W-1:0] pix [0:MEM_DEPTH-1];
    bit                 show_sel;
    bit                 swap_req;
    int                 pair;
    out_word_t          due [$];
    int                 errors;
    int                 results_seen;

    function new();
      foreach (pix[i]) pix[i] = '0;
      show_sel     = 1'b1;
      swap_req     = 1'b0;
      pair         = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function logic [COLOR_W-1:0] pixel(int row, int col);
      return pix[int'(show_sel) * BUF_SIZE + row * PANEL_COLUMNS + col];
    endfunction

    // colour pair for one shift clock of the current row pair
    function logic [RGB_W-1:0] shift_rgb(int clk_no);
      int top;
      int col;
      logic [COLOR_W-1:0] up, lo;
      top = ROW_PAIRS - 1 - pair;
      if (clk_no < PANEL_COLUMNS) begin
        col = PANEL_COLUMNS - 1 - clk_no;
        up  = pixel(top + ROW_PAIRS, col);
        lo  = pixel(top, col);
      end else begin
        col = clk_no - PANEL_COLUMNS;
        up  = pixel(pair + 2 * ROW_PAIRS, col);
        lo  = pixel(pair + 3 * ROW_PAIRS, col);
      end
      return {up, lo};
    endfunction

    function void note(in_word_t w);
      out_word_t r;
      bit        sw;
      case (w.cmd)
        CMD_WRITE: begin
          pix[int'(!show_sel) * BUF_SIZE + int'(w.pixel_y) * PANEL_COLUMNS
              + int'(w.pixel_x)] = w.pixel_color;
        end
        CMD_SWAP: begin
          swap_req = 1'b1;
        end
        CMD_TICK: begin
          sw   = 1'b0;
          pair = (pair + 1) % ROW_PAIRS;
          if (pair == 0 && swap_req) begin
            show_sel = !show_sel;
            swap_req = 1'b0;
            sw       = 1'b1;
          end
          for (int k = 0; k < PANEL_COLUMNS; k++) begin
            r.row_address      = pair[3:0];
            r.first_shift_rgb  = shift_rgb(2 * k);
            r.second_shift_rgb = shift_rgb(2 * k + 1);
            r.latch_now        = (k == PANEL_COLUMNS - 1);
            r.swapped          = sw;
            due.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(out_word_t got);
      out_word_t exp;
      results_seen++;
      if (due.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp = due.pop_front();
      if (got.row_address !== exp.row_address) begin
        $error("row_address expected %0d actual %0d", exp.row_address, got.row_address);
        errors++;
      end
      if (got.first_shift_rgb !== exp.first_shift_rgb) begin
        $error("first_shift_rgb expected %o actual %o",
               exp.first_shift_rgb, got.first_shift_rgb);
        errors++;
      end
      if (got.second_shift_rgb !== exp.second_shift_rgb) begin
        $error("second_shift_rgb expected %o actual %o",
               exp.second_shift_rgb, got.second_shift_rgb);
        errors++;
      end
      if (got.latch_now !== exp.latch_now) begin
        $error("latch_now expected %0d actual %0d", exp.latch_now, got.latch_now);
        errors++;
      end
      if (got.swapped !== exp.swapped) begin
        $error("swapped expected %0d actual %0d", exp.swapped, got.swapped);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  panel_scoreboard sb;
  bit              held_off;

  led_matrix_scan_driver_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("FAIL led_matrix_scan_driver_top");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note(in_word);
      if (out_valid && out_ready) sb.check(out_word);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] cmd, int x, int y, int colour);
    in_word_t w;
    w.cmd         = cmd;
    w.pixel_x     = x[5:0];
    w.pixel_y     = y[5:0];
    w.pixel_color = colour[2:0];
    send_word(w);
  endtask

  task automatic random_gap();
    while ($urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick          = $urandom_range(0, 99);
    w.pixel_x     = 6'($urandom);
    w.pixel_y     = 6'($urandom);
    w.pixel_color = 3'($urandom);
    if (pick < 55)      w.cmd = CMD_WRITE;
    else if (pick < 62) w.cmd = CMD_SWAP;
    else if (pick < 95) w.cmd = CMD_TICK;
    else                w.cmd = CMD_UNUSED;
    return w;
  endfunction

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    out_ready = 1'b0;
    held_off  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && sb.results_seen >= 1500) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (700) @(negedge clk);
      end else if (sb.results_seen >= 3000 && sb.results_seen < 4500) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    in_word_t w;
    int       n;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // a tick, the four corners, one inner pixel and an unused command, then a swap held until the row counter wraps
    send_fields(CMD_TICK, 0, 0, 0);
    send_fields(CMD_WRITE, 0, 0, 7);
    send_fields(CMD_WRITE, 63, 63, 5);
    send_fields(CMD_WRITE, 63, 0, 2);
    send_fields(CMD_WRITE, 0, 63, 1);
    send_fields(CMD_WRITE, 10, 15, 4);
    send_fields(CMD_UNUSED, 63, 63, 7);
    send_fields(CMD_SWAP, 63, 63, 7);
    send_fields(CMD_SWAP, 0, 0, 0);
    repeat (15) send_fields(CMD_TICK, 63, 63, 7);
    drain();

    n = 0;
    while (n < RANDOM_WORDS) begin
      w = random_word();
      if (n == 200) drain();
      if (n < 100 || n >= 160) random_gap();
      send_word(w);
      if (w.cmd != CMD_UNUSED) n++;
    end
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (sb.errors == 0 && sb.due.size() == 0)
      $display("PASS led_matrix_scan_driver_top");
    else
      $display("FAIL led_matrix_scan_driver_top");
    $finish;
  end

endmodule
